// ===== rtl/pal_pkg.sv =====
// Package for the per-address admission limiter: widths, codes, payload types.
// No dependencies.
package pal_pkg;
	localparam int COUNTER_ENTRIES = 64;
	localparam int OVERRIDE_ENTRIES = 16;
	localparam int CIDX_W = $clog2(COUNTER_ENTRIES);
	localparam int OIDX_W = $clog2(OVERRIDE_ENTRIES);
	localparam int PADDR_W = 5;

	localparam logic [2:0] CMD_ACCESS = 3'd0;
	localparam logic [2:0] CMD_PENALTY = 3'd1;
	localparam logic [2:0] CMD_TICK = 3'd2;
	localparam logic [2:0] CMD_CLEAR = 3'd3;
	localparam logic [2:0] CMD_ADD = 3'd4;

	localparam logic [1:0] V_ADMIT = 2'd0;
	localparam logic [1:0] V_SLOW = 2'd1;
	localparam logic [1:0] V_REJECT = 2'd2;
	localparam logic [1:0] V_NONE = 2'd3;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_DUP = 2'd2;

	localparam logic [2:0] REG_ABS = 3'd0;
	localparam logic [2:0] REG_SLOW = 3'd1;
	localparam logic [2:0] REG_PEN = 3'd2;
	localparam logic [2:0] REG_DELAY = 3'd3;
	localparam logic [2:0] REG_PERIOD = 3'd4;

	typedef struct packed {
		logic [2:0] command;
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [31:0] override_absolute;
		logic [31:0] override_slowdown;
	} in_item_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [31:0] delay;
		logic [31:0] attempts;
		logic [1:0] status;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;     // capture input transaction
		logic search;   // scan one entry of each table
		logic apply;    // update tables and form the result
	} pal_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
	} pal_status_t;
endpackage

// ===== rtl/pal_ctrl.sv =====
// Controller state machine for the admission limiter.
// Depends on pal_pkg.
module pal_ctrl import pal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic out_stall,
	input pal_status_t st,
	output logic in_stall,
	output logic out_valid,
	output pal_cmd_t cmd
);
	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_APPLY = 4'b0100,
		S_OUT = 4'b1000
	} state_t;
	state_t state_q;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		cmd = '0;
		cmd.load = (state_q == S_IDLE) && in_valid;
		cmd.search = (state_q == S_SCAN);
		cmd.apply = (state_q == S_APPLY);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SCAN;
				S_SCAN: if (st.scan_done) state_q <= S_APPLY;
				S_APPLY: state_q <= S_OUT;
				S_OUT: if (!out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== rtl/pal_dp.sv =====
// Datapath: table scans, counter update and verdict formation.
// Depends on pal_pkg.
module pal_dp import pal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input pal_cmd_t cmd,
	input in_item_t in_item,
	input logic [31:0] def_abs,
	input logic [31:0] def_slow,
	input logic [31:0] penalty,
	input logic [31:0] slow_delay,
	input logic [15:0] period,
	output pal_status_t st,
	output out_item_t out_item
);
	localparam int CSCAN_W = CIDX_W + 1;
	localparam int OSCAN_W = OIDX_W + 1;

	// counter table: read one entry a cycle, data registered before the compare;
	// override table: small, compared straight from its registers
	logic [63:0] ck_hi_q [COUNTER_ENTRIES];
	logic [63:0] ck_lo_q [COUNTER_ENTRIES];
	logic [31:0] cnt_q [COUNTER_ENTRIES];
	logic [COUNTER_ENTRIES-1:0] cvalid_q;
	logic [63:0] ok_hi_q [OVERRIDE_ENTRIES];
	logic [63:0] ok_lo_q [OVERRIDE_ENTRIES];
	logic [63:0] olim_q [OVERRIDE_ENTRIES];
	logic [OVERRIDE_ENTRIES-1:0] ovalid_q;
	logic [15:0] tick_q;

	in_item_t item_q;
	logic [CSCAN_W-1:0] cscan_q;
	logic [OSCAN_W-1:0] oscan_q;
	logic chit_q, cfree_q, ohit_q, ofree_q;
	logic [CIDX_W-1:0] cidx_q, cfidx_q;
	logic [OIDX_W-1:0] oidx_q, ofidx_q;
	logic [31:0] cnt_hit_q;
	out_item_t res_q;

	// registered read of the counter table
	logic crd_live_s1, crd_valid_s1;
	logic [63:0] crd_hi_s1, crd_lo_s1;
	logic [31:0] crd_cnt_s1;
	logic [CIDX_W-1:0] crd_idx_s1;

	logic [CIDX_W-1:0] cs;
	logic [OIDX_W-1:0] os;
	logic cdone, odone, cmatch, omatch;
	assign cs = cscan_q[CIDX_W-1:0];
	assign os = oscan_q[OIDX_W-1:0];
	assign cdone = (cscan_q == CSCAN_W'(COUNTER_ENTRIES));
	assign odone = (oscan_q == OSCAN_W'(OVERRIDE_ENTRIES));
	assign cmatch = crd_valid_s1 && crd_hi_s1 == item_q.address_high
		&& crd_lo_s1 == item_q.address_low;
	assign omatch = ovalid_q[os] && ok_hi_q[os] == item_q.address_high
		&& ok_lo_q[os] == item_q.address_low;
	assign st.scan_done = cdone && odone && !crd_live_s1;
	assign out_item = res_q;

	// update arithmetic and the result
	logic [CIDX_W-1:0] k;
	logic [31:0] base, addend, abs_lim, slow_lim, newc;
	logic [32:0] sum;
	logic [15:0] tick_nx;
	out_item_t res_nx;
	always_comb begin
		k = chit_q ? cidx_q : cfidx_q;
		base = chit_q ? cnt_hit_q : 32'd0;
		addend = (item_q.command == CMD_ACCESS) ? 32'd1 : penalty;
		sum = {1'b0, base} + {1'b0, addend};
		newc = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		abs_lim = ohit_q ? olim_q[oidx_q][63:32] : def_abs;
		slow_lim = ohit_q ? olim_q[oidx_q][31:0] : def_slow;
		tick_nx = tick_q + 16'd1;
		res_nx = '{verdict: V_NONE, delay: 32'd0, attempts: 32'd0, status: ST_OK};
		case (item_q.command)
			CMD_ACCESS, CMD_PENALTY: begin
				if (chit_q || cfree_q) begin
					res_nx.attempts = newc;
					if (item_q.command == CMD_ACCESS) begin
						if (newc > abs_lim) begin
							res_nx.verdict = V_REJECT;
						end else if (newc > slow_lim) begin
							res_nx.verdict = V_SLOW;
							res_nx.delay = slow_delay;
						end else begin
							res_nx.verdict = V_ADMIT;
						end
					end
				end else begin
					res_nx.status = ST_FULL;
					if (item_q.command == CMD_ACCESS) res_nx.verdict = V_REJECT;
				end
			end
			CMD_ADD: begin
				if (ohit_q) begin
					res_nx.status = ST_DUP;
				end else if (!ofree_q) begin
					res_nx.status = ST_FULL;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvalid_q <= '0;
			ovalid_q <= '0;
			tick_q <= '0;
			cscan_q <= '0;
			oscan_q <= '0;
			crd_live_s1 <= 1'b0;
		end else begin
			crd_live_s1 <= cmd.search && !cdone;
			if (cmd.load) begin
				cscan_q <= '0;
				oscan_q <= '0;
			end else if (cmd.search) begin
				if (!cdone) cscan_q <= cscan_q + CSCAN_W'(1);
				if (!odone) oscan_q <= oscan_q + OSCAN_W'(1);
			end
			if (cmd.apply) begin
				case (item_q.command)
					CMD_ACCESS, CMD_PENALTY: begin
						if ((chit_q || cfree_q) && !chit_q) cvalid_q[k] <= 1'b1;
					end
					CMD_TICK: begin
						if (tick_nx >= period) begin
							cvalid_q <= '0;
							tick_q <= '0;
						end else begin
							tick_q <= tick_nx;
						end
					end
					CMD_CLEAR: begin
						cvalid_q <= '0;
						ovalid_q <= '0;
					end
					CMD_ADD: if (!ohit_q && ofree_q) ovalid_q[ofidx_q] <= 1'b1;
					default: ;
				endcase
			end
		end
	end

	// payload: no reset
	always_ff @(posedge clk) begin
		crd_hi_s1 <= ck_hi_q[cs];
		crd_lo_s1 <= ck_lo_q[cs];
		crd_cnt_s1 <= cnt_q[cs];
		crd_valid_s1 <= cvalid_q[cs];
		crd_idx_s1 <= cs;
		if (cmd.load) begin
			item_q <= in_item;
			chit_q <= 1'b0;
			cfree_q <= 1'b0;
			ohit_q <= 1'b0;
			ofree_q <= 1'b0;
			cidx_q <= '0;
			cfidx_q <= '0;
			oidx_q <= '0;
			ofidx_q <= '0;
		end else if (cmd.search) begin
			if (crd_live_s1) begin
				if (cmatch) begin
					chit_q <= 1'b1;
					cidx_q <= crd_idx_s1;
					cnt_hit_q <= crd_cnt_s1;
				end
				if (!crd_valid_s1 && !cfree_q) begin
					cfree_q <= 1'b1;
					cfidx_q <= crd_idx_s1;
				end
			end
			if (!odone) begin
				if (omatch) begin
					ohit_q <= 1'b1;
					oidx_q <= os;
				end
				if (!ovalid_q[os] && !ofree_q) begin
					ofree_q <= 1'b1;
					ofidx_q <= os;
				end
			end
		end
		if (cmd.apply) begin
			res_q <= res_nx;
			case (item_q.command)
				CMD_ACCESS, CMD_PENALTY: begin
					if (chit_q || cfree_q) begin
						cnt_q[k] <= newc;
						ck_hi_q[k] <= item_q.address_high;
						ck_lo_q[k] <= item_q.address_low;
					end
				end
				CMD_ADD: begin
					if (!ohit_q && ofree_q) begin
						ok_hi_q[ofidx_q] <= item_q.address_high;
						ok_lo_q[ofidx_q] <= item_q.address_low;
						olim_q[ofidx_q] <= {item_q.override_absolute, item_q.override_slowdown};
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ===== rtl/per_address_admission_limiter_core.sv =====
// Per-address admission limiter, top level: APB registers, controller, datapath.
// Sequence: after the input transaction is taken, the scan reads all 64 counter entries, compares
// behind the last read and signals done, then the apply step updates the tables and forms the result.
// Throughput: one transaction at a time; the next is taken only once the result has left.
// Reset clears all valid bits and the tick count and loads the register defaults at once; no sweep.
module per_address_admission_limiter_core import pal_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic [31:0] def_abs_q, def_slow_q, penalty_q, delay_q;
	logic [15:0] period_q;
	logic [2:0] ridx;
	pal_cmd_t cmd;
	pal_status_t st;

	// register index is the word address
	assign ridx = paddr[4:2];
	assign pready = 1'b1;

	always_comb begin
		case (ridx)
			REG_ABS: prdata = def_abs_q;
			REG_SLOW: prdata = def_slow_q;
			REG_PEN: prdata = penalty_q;
			REG_DELAY: prdata = delay_q;
			REG_PERIOD: prdata = {16'd0, period_q};
			default: prdata = 32'd0;
		endcase
	end

	// write on the access phase of a transaction; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_abs_q <= 32'd100;
			def_slow_q <= 32'd50;
			penalty_q <= 32'd10;
			delay_q <= 32'd1;
			period_q <= 16'd60;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_ABS: def_abs_q <= pwdata;
				REG_SLOW: def_slow_q <= pwdata;
				REG_PEN: penalty_q <= pwdata;
				REG_DELAY: delay_q <= pwdata;
				REG_PERIOD: period_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	pal_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .out_stall(out_stall),
		.st(st), .in_stall(in_stall), .out_valid(out_valid), .cmd(cmd)
	);

	pal_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_item(in_data),
		.def_abs(def_abs_q), .def_slow(def_slow_q), .penalty(penalty_q),
		.slow_delay(delay_q), .period(period_q), .st(st), .out_item(out_data)
	);

`ifndef SYNTH
	// a slow-down result always carries the configured delay
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.verdict == V_SLOW |-> out_data.delay == delay_q)
		else $error("slow verdict without delay");
	// input is never taken while a result is pending
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken with result pending");
	// a non-slow verdict reports zero delay
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.verdict != V_SLOW |-> out_data.delay == 32'd0)
		else $error("delay on non-slow verdict");
`endif
endmodule

// ===== bench/testbench.sv =====
// Testbench for per_address_admission_limiter_core: a directed table, then random traffic under four
// phases of input idling and output stalling, each result checked against a local admission predictor.
// Depends on pal_pkg and the core RTL only.
module testbench;
	import pal_pkg::*;

	localparam int CLK_HALF = 4;
	localparam int LATENCY = 80;          // load, 64-entry scan, apply, margin
	localparam int RANDOM_PER_PHASE = 400;
	localparam int POOL_SIZE = 80;        // more than the counter table holds
	localparam logic [2:0] CMD_RESERVED_FIRST = 3'd5;
	localparam logic [2:0] CMD_RESERVED_LAST = 3'd7;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_item_t in_data;
	logic out_valid;
	logic out_stall;
	out_item_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	per_address_admission_limiter_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor copy of the registers and tables
	logic [31:0] lim_absolute, lim_slowdown, penalty_amount, slow_delay;
	logic [15:0] clear_period, tick_seen;
	logic [63:0] ctr_key_hi [COUNTER_ENTRIES];
	logic [63:0] ctr_key_lo [COUNTER_ENTRIES];
	logic [31:0] ctr_attempts [COUNTER_ENTRIES];
	bit ctr_live [COUNTER_ENTRIES];
	logic [63:0] ovr_key_hi [OVERRIDE_ENTRIES];
	logic [63:0] ovr_key_lo [OVERRIDE_ENTRIES];
	logic [31:0] ovr_absolute [OVERRIDE_ENTRIES];
	logic [31:0] ovr_slowdown [OVERRIDE_ENTRIES];
	bit ovr_live [OVERRIDE_ENTRIES];

	out_item_t pending_verdicts [$];
	int error_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	logic [63:0] pool_hi [POOL_SIZE];
	logic [63:0] pool_lo [POOL_SIZE];

	typedef struct {
		in_item_t stim;
		bit typed;
		out_item_t want;
	} directed_row_t;

	task automatic report(input string what);
		$display("MISMATCH at %0t: %s", $time, what);
		error_count++;
	endtask

	function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic int override_slot(input logic [63:0] hi, input logic [63:0] lo);
		for (int i = 0; i < OVERRIDE_ENTRIES; i++)
			if (ovr_live[i] && ovr_key_hi[i] == hi && ovr_key_lo[i] == lo)
				return i;
		return -1;
	endfunction

	// find the address's counter, or claim the lowest free entry at zero
	function automatic int counter_slot(input logic [63:0] hi, input logic [63:0] lo);
		int spare;
		spare = -1;
		for (int i = 0; i < COUNTER_ENTRIES; i++) begin
			if (ctr_live[i]) begin
				if (ctr_key_hi[i] == hi && ctr_key_lo[i] == lo)
					return i;
			end else if (spare < 0) begin
				spare = i;
			end
		end
		if (spare >= 0) begin
			ctr_live[spare] = 1'b1;
			ctr_key_hi[spare] = hi;
			ctr_key_lo[spare] = lo;
			ctr_attempts[spare] = '0;
		end
		return spare;
	endfunction

	function automatic out_item_t predict_admission(input in_item_t t);
		out_item_t r;
		logic [31:0] abs_lim, slow_lim;
		int o, k;
		r = '{verdict: V_NONE, delay: '0, attempts: '0, status: ST_OK};
		case (t.command)
			CMD_ACCESS: begin
				abs_lim = lim_absolute;
				slow_lim = lim_slowdown;
				o = override_slot(t.address_high, t.address_low);
				if (o >= 0) begin
					abs_lim = ovr_absolute[o];
					slow_lim = ovr_slowdown[o];
				end
				k = counter_slot(t.address_high, t.address_low);
				if (k < 0) begin
					r.verdict = V_REJECT;
					r.status = ST_FULL;
				end else begin
					ctr_attempts[k] = sat_sum(ctr_attempts[k], 32'd1);
					r.attempts = ctr_attempts[k];
					if (r.attempts > abs_lim) begin
						r.verdict = V_REJECT;
					end else if (r.attempts > slow_lim) begin
						r.verdict = V_SLOW;
						r.delay = slow_delay;
					end else begin
						r.verdict = V_ADMIT;
					end
				end
			end
			CMD_PENALTY: begin
				k = counter_slot(t.address_high, t.address_low);
				if (k < 0) begin
					r.status = ST_FULL;
				end else begin
					ctr_attempts[k] = sat_sum(ctr_attempts[k], penalty_amount);
					r.attempts = ctr_attempts[k];
				end
			end
			CMD_TICK: begin
				tick_seen = tick_seen + 16'd1;
				if (tick_seen >= clear_period) begin
					ctr_live = '{default: 1'b0};
					tick_seen = '0;
				end
			end
			CMD_CLEAR: begin
				ovr_live = '{default: 1'b0};
				ctr_live = '{default: 1'b0};
			end
			CMD_ADD: begin
				if (override_slot(t.address_high, t.address_low) >= 0) begin
					r.status = ST_DUP;
				end else begin
					r.status = ST_FULL;
					for (int i = 0; i < OVERRIDE_ENTRIES; i++) begin
						if (!ovr_live[i] && r.status == ST_FULL) begin
							ovr_live[i] = 1'b1;
							ovr_key_hi[i] = t.address_high;
							ovr_key_lo[i] = t.address_low;
							ovr_absolute[i] = t.override_absolute;
							ovr_slowdown[i] = t.override_slowdown;
							r.status = ST_OK;
						end
					end
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// watchdog: far beyond the slowest correct run
	initial begin
		#(2 * CLK_HALF * 2_000_000);
		$display("testbench failed");
		$finish;
	end

	// result side: check each accepted transaction, then pick the next stall
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				report("result with nothing expected");
			end else begin
				want = pending_verdicts.pop_front();
				if (out_data.verdict !== want.verdict)
					report($sformatf("verdict %0d, expected %0d", out_data.verdict, want.verdict));
				if (out_data.delay !== want.delay)
					report($sformatf("delay %0h, expected %0h", out_data.delay, want.delay));
				if (out_data.attempts !== want.attempts)
					report($sformatf("attempts %0h, expected %0h",
						out_data.attempts, want.attempts));
				if (out_data.status !== want.status)
					report($sformatf("status %0d, expected %0d", out_data.status, want.status));
			end
		end
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// offer one transaction, hold it until accepted, then record the expectation
	task automatic send_item(input in_item_t t, input bit typed, input out_item_t want);
		int gap;
		out_item_t got;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct && gap < 40)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= t;
		do @(posedge clk); while (in_stall);
		got = predict_admission(t);
		pending_verdicts.push_back(typed ? want : got);
	endtask

	// pause until every result is back and the block has gone quiet
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (LATENCY) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (index)
			REG_ABS: lim_absolute = value;
			REG_SLOW: lim_slowdown = value;
			REG_PEN: penalty_amount = value;
			REG_DELAY: slow_delay = value;
			REG_PERIOD: clear_period = value[15:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [31:0] a, input logic [31:0] s,
			input logic [31:0] p, input logic [31:0] d, input logic [15:0] per);
		drain();
		write_reg(REG_ABS, a);
		write_reg(REG_SLOW, s);
		write_reg(REG_PEN, p);
		write_reg(REG_DELAY, d);
		write_reg(REG_PERIOD, {16'd0, per});
	endtask

	// mostly a hot handful of addresses; sometimes the wider pool to fill the table
	function automatic in_item_t random_item();
		in_item_t t;
		int pick, c;
		pick = ($urandom_range(99) < 75) ? $urandom_range(11) : $urandom_range(POOL_SIZE - 1);
		t.address_high = pool_hi[pick];
		t.address_low = pool_lo[pick];
		t.override_absolute = $urandom_range(1) ? 32'($urandom_range(8)) : 32'($urandom);
		t.override_slowdown = $urandom_range(1) ? 32'($urandom_range(6)) : 32'($urandom);
		c = $urandom_range(99);
		if (c < 55) t.command = CMD_ACCESS;
		else if (c < 70) t.command = CMD_PENALTY;
		else if (c < 82) t.command = CMD_TICK;
		else if (c < 84) t.command = CMD_CLEAR;
		else if (c < 96) t.command = CMD_ADD;
		else t.command = 3'($urandom_range(CMD_RESERVED_FIRST, CMD_RESERVED_LAST));
		return t;
	endfunction

	task automatic random_phase(input int idle, input int stall);
		out_item_t none;
		none = '0;
		send_idle_pct = idle;
		stall_pct = stall;
		for (int n = 0; n < RANDOM_PER_PHASE; n++)
			send_item(random_item(), 1'b0, none);
	endtask

	initial begin
		directed_row_t rows [$];
		logic [63:0] ones, v4_hi, v4_lo;
		ones = '1;
		v4_hi = 64'h0;
		v4_lo = 64'h0000_FFFF_C0A8_0001;   // an IPv4-mapped source

		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;

		// register and table state after reset
		lim_absolute = 32'd100;
		lim_slowdown = 32'd50;
		penalty_amount = 32'd10;
		slow_delay = 32'd1;
		clear_period = 16'd60;
		tick_seen = '0;
		ctr_live = '{default: 1'b0};
		ovr_live = '{default: 1'b0};
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_hi[i] = {$urandom, $urandom};
			pool_lo[i] = {$urandom, $urandom};
		end
		pool_hi[0] = '0;
		pool_lo[0] = '0;
		pool_hi[1] = ones;
		pool_lo[1] = ones;
		pool_hi[2] = v4_hi;
		pool_lo[2] = v4_lo;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: typed expectations where they follow from the reset defaults
		rows.push_back('{'{CMD_ACCESS, 64'h0, 64'h0, 32'h0, 32'h0}, 1,
			'{V_ADMIT, 32'd0, 32'd1, ST_OK}});
		rows.push_back('{'{CMD_ACCESS, ones, ones, ones[31:0], ones[31:0]}, 1,
			'{V_ADMIT, 32'd0, 32'd1, ST_OK}});
		rows.push_back('{'{CMD_PENALTY, 64'h0, 64'h0, 32'h0, 32'h0}, 1,
			'{V_NONE, 32'd0, 32'd11, ST_OK}});
		rows.push_back('{'{CMD_ADD, v4_hi, v4_lo, 32'd2, 32'd1}, 1,
			'{V_NONE, 32'd0, 32'd0, ST_OK}});
		rows.push_back('{'{CMD_ADD, v4_hi, v4_lo, 32'd9, 32'd9}, 1,
			'{V_NONE, 32'd0, 32'd0, ST_DUP}});
		rows.push_back('{'{CMD_ACCESS, v4_hi, v4_lo, 32'h0, 32'h0}, 1,
			'{V_ADMIT, 32'd0, 32'd1, ST_OK}});
		rows.push_back('{'{CMD_ACCESS, v4_hi, v4_lo, 32'h0, 32'h0}, 1,
			'{V_SLOW, 32'd1, 32'd2, ST_OK}});
		rows.push_back('{'{CMD_ACCESS, v4_hi, v4_lo, 32'h0, 32'h0}, 1,
			'{V_REJECT, 32'd0, 32'd3, ST_OK}});
		rows.push_back('{'{CMD_TICK, ones, ones, 32'h0, 32'h0}, 1,
			'{V_NONE, 32'd0, 32'd0, ST_OK}});
		rows.push_back('{'{CMD_RESERVED_FIRST, ones, ones, ones[31:0], ones[31:0]}, 1,
			'{V_NONE, 32'd0, 32'd0, ST_OK}});
		rows.push_back('{'{CMD_RESERVED_LAST, ones, ones, ones[31:0], ones[31:0]}, 1,
			'{V_NONE, 32'd0, 32'd0, ST_OK}});
		rows.push_back('{'{CMD_CLEAR, 64'h0, 64'h0, 32'h0, 32'h0}, 1,
			'{V_NONE, 32'd0, 32'd0, ST_OK}});
		rows.push_back('{'{CMD_ACCESS, v4_hi, v4_lo, 32'h0, 32'h0}, 1,
			'{V_ADMIT, 32'd0, 32'd1, ST_OK}});
		rows.push_back('{'{CMD_ADD, ones, ones, ones[31:0], ones[31:0]}, 0, '0});
		rows.push_back('{'{CMD_ADD, 64'h0, 64'h0, 32'h0, 32'h0}, 0, '0});
		rows.push_back('{'{CMD_ACCESS, 64'h0, 64'h0, 32'h0, 32'h0}, 0, '0});
		rows.push_back('{'{CMD_PENALTY, ones, ones, 32'h0, 32'h0}, 0, '0});
		rows.push_back('{'{CMD_ACCESS, ones, ones, 32'h0, 32'h0}, 0, '0});
		// sixteen distinct adds overflow the override table
		for (int i = 0; i < OVERRIDE_ENTRIES; i++)
			rows.push_back('{'{CMD_ADD, pool_hi[i + 3], pool_lo[i + 3], 32'd4, 32'd2}, 0, '0});
		foreach (rows[i])
			send_item(rows[i].stim, rows[i].typed, rows[i].want);

		// the settings load also makes the sender wait out every result
		load_settings('1, '1, '1, '1, 16'd1);
		random_phase(0, 0);
		load_settings(32'd6, 32'd3, 32'd2, 32'd7, 16'd0);
		random_phase(58, 0);
		load_settings(32'd0, 32'd0, 32'd0, 32'd0, 16'hFFFF);
		random_phase(0, 58);
		load_settings(32'd20, 32'd8, 32'd3, 32'd123, 16'd5);
		random_phase(34, 34);

		drain();
		if (error_count == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
